// ===== hw/rtl/path_smoothing_sweep_unit_assert.svh =====
// assertion macros for the path smoothing sweep unit
`ifndef PATH_SMOOTHING_SWEEP_UNIT_ASSERT_SVH
`define PATH_SMOOTHING_SWEEP_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PSS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pss assertion failed");
`define PSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pss assertion failed");
`else
`define PSS_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define PSS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/pss_pkg.sv =====
// shared types and constants of the path smoothing sweep unit
`timescale 1ns / 1ps
package pss_pkg;
   localparam int MAX_POINTS_DEF = 64;
   localparam int MAX_REFINEMENTS_DEF = 4;
   localparam int REF_W = 3;
   localparam int COORD_W = 32;
   localparam int CHANGE_W = 40;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [15:0] weight_type;

   localparam logic [2:0] CSR_DATA_WEIGHT = 3'd0;
   localparam logic [2:0] CSR_SMOOTH_WEIGHT = 3'd1;
   localparam logic [2:0] CSR_TOLERANCE = 3'd2;
   localparam logic [2:0] CSR_MAX_ITERATIONS = 3'd3;
   localparam logic [2:0] CSR_REFINE_ENABLE = 3'd4;

   localparam weight_type DATA_WEIGHT_RST = 16'd6554;
   localparam weight_type SMOOTH_WEIGHT_RST = 16'd19661;
   localparam logic [31:0] TOLERANCE_RST = 32'd655;
   localparam logic [15:0] MAX_ITERATIONS_RST = 16'd1000;
endpackage

// ===== hw/rtl/pss_ram.sv =====
// single write, single registered read port memory
`timescale 1ns / 1ps
module pss_ram import pss_pkg::*; #(
   parameter int DEPTH = MAX_POINTS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  coord_type                wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output coord_type                rdata
);
   coord_type mem [DEPTH];
   coord_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/pss_update.sv =====
// two stage update of one coordinate: weighted pulls, rounding, saturation
`timescale 1ns / 1ps
module pss_update import pss_pkg::*; (
   input  logic        clock,
   input  weight_type  data_weight,
   input  weight_type  smooth_weight,
   input  coord_type   prev,
   input  coord_type   cur,
   input  coord_type   nxt,
   input  coord_type   orig,
   output coord_type   new_val,
   output logic [32:0] diff
);
   logic signed [16:0] dw_s, sw_s;
   logic signed [32:0] d_data;
   logic signed [34:0] d_smooth;
   logic signed [49:0] pd_in, pd_ff;
   logic signed [51:0] ps_in, ps_ff;
   logic signed [52:0] acc;
   logic signed [36:0] delta;
   logic signed [37:0] sum;
   coord_type          sat;
   logic signed [32:0] dd;
   coord_type          new_ff;
   logic [32:0]        diff_ff;

   always_comb begin
      dw_s = $signed({1'b0, data_weight});
      sw_s = $signed({1'b0, smooth_weight});
      d_data = 33'(orig) - 33'(cur);
      d_smooth = 35'(nxt) + 35'(prev) - (35'(cur) <<< 1);
      pd_in = 50'(dw_s) * 50'(d_data);
      ps_in = 52'(sw_s) * 52'(d_smooth);
      acc = 53'(pd_ff) + 53'(ps_ff) + 53'sd32768;
      delta = acc[52:16];
      sum = 38'(cur) + 38'(delta);
      if (sum > 38'sd2147483647) begin
         sat = 32'sh7fffffff;
      end else if (sum < -38'sd2147483648) begin
         sat = 32'sh80000000;
      end else begin
         sat = sum[31:0];
      end
      dd = 33'(sat) - 33'(cur);
   end

   always_ff @(posedge clock) begin
      pd_ff <= pd_in;
      ps_ff <= ps_in;
      new_ff <= sat;
      diff_ff <= dd[32] ? 33'(-dd) : 33'(dd);
   end

   assign new_val = new_ff;
   assign diff = diff_ff;
endmodule

// ===== hw/rtl/path_smoothing_sweep_unit.sv =====
// path smoothing sweep unit: point stores, sweep sequencer and result stream
//
// usage
//   req_ carries path points, one beat per point, tlast on the final point.
//   points load one per cycle; beyond MAX_POINTS they are dropped.
//   after the tlast beat the block sweeps the stored path and then streams
//   every point on rsp_, tlast on the last one, tuser = converged.
//   one interior point update steps through S_RDA, S_RDB, S_RDC, S_MUL, S_ACC
//   and S_WR (three reads of the working store through its single read port,
//   a multiply stage, a rounding stage and the write back); a sweep updates
//   each interior point in turn, a pass sweeps until the change falls below
//   tolerance or max_iterations is reached. each refinement pass is preceded
//   by a copy of n points; emission holds each point until it is taken.
//   req_tready is high only while loading; a stalled receiver holds the
//   current rsp beat and the block waits.
//   reset (synchronous) clears the point count and the sequencer and restores
//   the register defaults; store contents are not cleared.
//   csr_ writes take effect at the next edge; issue them only while idle.
`timescale 1ns / 1ps
`include "path_smoothing_sweep_unit_assert.svh"
module path_smoothing_sweep_unit import pss_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int MAX_REFINEMENTS = MAX_REFINEMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // point_x, point_y
   input  logic        req_tlast,   // last_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // smooth_x, smooth_y
   output logic        rsp_tlast,   // end_of_path
   output logic        rsp_tuser,   // converged
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [10:0] {
      S_LOAD  = 11'b00000000001,
      S_PASS  = 11'b00000000010,
      S_CHECK = 11'b00000000100,
      S_RDA   = 11'b00000001000,
      S_RDB   = 11'b00000010000,
      S_RDC   = 11'b00000100000,
      S_MUL   = 11'b00001000000,
      S_ACC   = 11'b00010000000,
      S_WR    = 11'b00100000000,
      S_COPY  = 11'b01000000000,
      S_EMIT  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   weight_type dw_ff, sw_ff;
   logic [31:0] tol_ff;
   logic [15:0] maxit_ff;
   logic refen_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in, n_ff, n_in, idx_ff, idx_in;
   logic [15:0] sweep_ff, sweep_in;
   logic [REF_W-1:0] ref_ff, ref_in;
   logic [CHANGE_W-1:0] cs_ff, cs_in;
   logic ok_ff, ok_in;
   logic phase_ff, phase_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_last_ff, rsp_last_in;
   coord_type rsp_x_ff, rsp_y_ff, rsp_x_in, rsp_y_in;
   coord_type prev_x_ff, prev_y_ff, cur_x_ff, cur_y_ff;
   coord_type prev_x_in, prev_y_in, cur_x_in, cur_y_in;

   logic work_we, orig_we;
   logic [IDX_W-1:0] work_waddr, orig_waddr, work_raddr, orig_raddr;
   coord_type work_wx, work_wy, orig_wx, orig_wy;
   coord_type work_rx, work_ry, orig_rx, orig_ry;
   coord_type new_x, new_y;
   logic [32:0] diff_x, diff_y;
   logic [CHANGE_W+1:0] cs_sum;
   logic [16:0] sweep_next;
   logic in_acc, out_acc;

   pss_ram #(.DEPTH(MAX_POINTS)) u_orig_x (.clock, .we(orig_we), .waddr(orig_waddr),
      .wdata(orig_wx), .raddr(orig_raddr), .rdata(orig_rx));
   pss_ram #(.DEPTH(MAX_POINTS)) u_orig_y (.clock, .we(orig_we), .waddr(orig_waddr),
      .wdata(orig_wy), .raddr(orig_raddr), .rdata(orig_ry));
   pss_ram #(.DEPTH(MAX_POINTS)) u_work_x (.clock, .we(work_we), .waddr(work_waddr),
      .wdata(work_wx), .raddr(work_raddr), .rdata(work_rx));
   pss_ram #(.DEPTH(MAX_POINTS)) u_work_y (.clock, .we(work_we), .waddr(work_waddr),
      .wdata(work_wy), .raddr(work_raddr), .rdata(work_ry));

   pss_update u_upd_x (.clock, .data_weight(dw_ff), .smooth_weight(sw_ff),
      .prev(prev_x_ff), .cur(cur_x_ff), .nxt(work_rx), .orig(orig_rx),
      .new_val(new_x), .diff(diff_x));
   pss_update u_upd_y (.clock, .data_weight(dw_ff), .smooth_weight(sw_ff),
      .prev(prev_y_ff), .cur(cur_y_ff), .nxt(work_ry), .orig(orig_ry),
      .new_val(new_y), .diff(diff_y));

   assign in_acc = req_tvalid && req_tready;
   assign out_acc = rsp_valid_ff && rsp_tready;
   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_y_ff, rsp_x_ff};
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = ok_ff;

   assign orig_raddr = idx_ff[IDX_W-1:0];
   assign cs_sum = (CHANGE_W+2)'(cs_ff) + (CHANGE_W+2)'(diff_x) + (CHANGE_W+2)'(diff_y);
   assign sweep_next = 17'(sweep_ff) + 17'd1;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      idx_in = idx_ff;
      sweep_in = sweep_ff;
      ref_in = ref_ff;
      cs_in = cs_ff;
      ok_in = ok_ff;
      phase_in = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in = rsp_last_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      work_we = 1'b0;
      orig_we = 1'b0;
      work_waddr = cnt_ff[IDX_W-1:0];
      orig_waddr = cnt_ff[IDX_W-1:0];
      work_wx = req_tdata[31:0];
      work_wy = req_tdata[63:32];
      orig_wx = req_tdata[31:0];
      orig_wy = req_tdata[63:32];
      work_raddr = idx_ff[IDX_W-1:0];
      case (state_ff)
         S_LOAD: begin
            if (in_acc) begin
               if (cnt_ff < CNT_W'(MAX_POINTS)) begin
                  work_we = 1'b1;
                  orig_we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_tlast) begin
                  n_in = (cnt_ff < CNT_W'(MAX_POINTS)) ? cnt_ff + 1'b1 : cnt_ff;
                  ref_in = '0;
                  state_in = S_PASS;
               end
            end
         end
         S_PASS: begin
            sweep_in = '0;
            cs_in = CHANGE_W'(tol_ff);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (cs_ff >= CHANGE_W'(tol_ff)) begin
               sweep_in = sweep_next[15:0];
               cs_in = '0;
               idx_in = CNT_W'(1);
               if (sweep_next >= 17'(maxit_ff)) begin
                  if (ref_ff == '0) begin
                     ok_in = 1'b0;
                  end
                  idx_in = '0;
                  phase_in = 1'b0;
                  state_in = S_EMIT;
               end else if (n_ff >= CNT_W'(3)) begin
                  state_in = S_RDA;
               end
            end else begin
               if (ref_ff == '0) begin
                  ok_in = 1'b1;
               end
               idx_in = '0;
               phase_in = 1'b0;
               if (refen_ff && (32'(ref_ff) < 32'(MAX_REFINEMENTS))) begin
                  ref_in = ref_ff + 1'b1;
                  state_in = S_COPY;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_RDA: begin
            work_raddr = IDX_W'(idx_ff - 1'b1);
            state_in = S_RDB;
         end
         S_RDB: begin
            prev_x_in = work_rx;
            prev_y_in = work_ry;
            state_in = S_RDC;
         end
         S_RDC: begin
            cur_x_in = work_rx;
            cur_y_in = work_ry;
            work_raddr = IDX_W'(idx_ff + 1'b1);
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            state_in = S_WR;
         end
         S_WR: begin
            work_we = 1'b1;
            work_waddr = idx_ff[IDX_W-1:0];
            work_wx = new_x;
            work_wy = new_y;
            cs_in = (cs_sum > (CHANGE_W+2)'({CHANGE_W{1'b1}})) ? {CHANGE_W{1'b1}}
                                                             : cs_sum[CHANGE_W-1:0];
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + CNT_W'(2) < n_ff) ? S_RDA : S_CHECK;
         end
         S_COPY: begin
            if (phase_ff) begin
               orig_we = 1'b1;
               orig_waddr = idx_ff[IDX_W-1:0];
               orig_wx = work_rx;
               orig_wy = work_ry;
               idx_in = idx_ff + 1'b1;
               phase_in = 1'b0;
               if (idx_ff + 1'b1 == n_ff) begin
                  state_in = S_PASS;
               end
            end else begin
               phase_in = 1'b1;
            end
         end
         S_EMIT: begin
            if (rsp_valid_ff) begin
               if (out_acc) begin
                  rsp_valid_in = 1'b0;
                  phase_in = 1'b0;
                  if (rsp_last_ff) begin
                     cnt_in = '0;
                     state_in = S_LOAD;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end else if (phase_ff) begin
               rsp_x_in = work_rx;
               rsp_y_in = work_ry;
               rsp_last_in = (idx_ff + 1'b1 == n_ff);
               rsp_valid_in = 1'b1;
            end else begin
               phase_in = 1'b1;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff <= '0;
         n_ff <= '0;
         idx_ff <= '0;
         sweep_ff <= '0;
         ref_ff <= '0;
         cs_ff <= '0;
         ok_ff <= 1'b0;
         phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
         dw_ff <= DATA_WEIGHT_RST;
         sw_ff <= SMOOTH_WEIGHT_RST;
         tol_ff <= TOLERANCE_RST;
         maxit_ff <= MAX_ITERATIONS_RST;
         refen_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         n_ff <= n_in;
         idx_ff <= idx_in;
         sweep_ff <= sweep_in;
         ref_ff <= ref_in;
         cs_ff <= cs_in;
         ok_ff <= ok_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff <= rsp_last_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_DATA_WEIGHT:    dw_ff <= csr_wdata[15:0];
               CSR_SMOOTH_WEIGHT:  sw_ff <= csr_wdata[15:0];
               CSR_TOLERANCE:      tol_ff <= csr_wdata;
               CSR_MAX_ITERATIONS: maxit_ff <= csr_wdata[15:0];
               CSR_REFINE_ENABLE:  refen_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
   end

   `PSS_ASSERT_SAME(a_rsp_only_emit, clock, reset, rsp_valid_ff, state_ff == S_EMIT)
   `PSS_ASSERT_SAME(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_POINTS))
   `PSS_ASSERT_SAME(a_wr_interior, clock, reset, state_ff == S_WR,
      (idx_ff >= CNT_W'(1)) && (idx_ff + CNT_W'(2) <= n_ff))
   `PSS_ASSERT_NEXT(a_last_idle, clock, reset, out_acc && rsp_last_ff,
      (state_ff == S_LOAD) && (cnt_ff == '0))
endmodule

// ===== test/path_smoothing_sweep_unit_tb.sv =====
// testbench for the path smoothing sweep unit: directed and random paths
// checked beat by beat against a fixed-point smoothing predictor
`timescale 1ns / 1ps
module path_smoothing_sweep_unit_tb;
   import pss_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int PASS_LIMIT = 4;
   localparam int STALL_LIMIT = 300000;
   localparam int HOLD_LEN = 4000;
   localparam longint CHANGE_CAP = (longint'(1) << 40) - 1;

   typedef struct {
      coord_type sx;
      coord_type sy;
      bit        eop;
      bit        conv;
   } point_beat_type;

   class smoothing_scoreboard_type;
      coord_type      orig[2][STORE_DEPTH];
      coord_type      work[2][STORE_DEPTH];
      int             count;
      longint         change;
      longint         w_data, w_smooth, tol, max_sweeps;
      bit             refine_on;
      point_beat_type expected_points[$];
      int             errors, checked, paths;

      function new();
         count = 0;
         w_data = DATA_WEIGHT_RST;
         w_smooth = SMOOTH_WEIGHT_RST;
         tol = TOLERANCE_RST;
         max_sweeps = MAX_ITERATIONS_RST;
         refine_on = 1;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            CSR_DATA_WEIGHT: w_data = val[15:0];
            CSR_SMOOTH_WEIGHT: w_smooth = val[15:0];
            CSR_TOLERANCE: tol = val;
            CSR_MAX_ITERATIONS: max_sweeps = val[15:0];
            CSR_REFINE_ENABLE: refine_on = val[0];
            default: ;
         endcase
      endfunction

      function void relax(int ax, int i);
         longint y, acc, ny, diff;
         y = work[ax][i];
         acc = w_data * (longint'(orig[ax][i]) - y)
             + w_smooth * (longint'(work[ax][i+1]) + longint'(work[ax][i-1]) - 2 * y);
         ny = y + ((acc + 32768) >>> 16);
         if (ny > 64'sd2147483647) ny = 64'sd2147483647;
         if (ny < -64'sd2147483648) ny = -64'sd2147483648;
         work[ax][i] = ny[31:0];
         diff = (ny >= y) ? ny - y : y - ny;
         change += diff;
         if (change > CHANGE_CAP) change = CHANGE_CAP;
      endfunction

      function bit smooth_pass(int n);
         longint sweeps;
         sweeps = 0;
         change = tol;
         while (change >= tol) begin
            sweeps++;
            change = 0;
            if (sweeps >= max_sweeps) return 0;
            for (int i = 1; i + 1 < n; i++) begin
               relax(0, i);
               relax(1, i);
            end
         end
         return 1;
      endfunction

      function void note_point(coord_type x, coord_type y, bit last);
         bit ok;
         int refines;
         point_beat_type b;
         if (count < STORE_DEPTH) begin
            orig[0][count] = x;
            orig[1][count] = y;
            work[0][count] = x;
            work[1][count] = y;
            count++;
         end
         if (!last) return;
         paths++;
         refines = 0;
         ok = smooth_pass(count);
         if (ok) begin
            while (refine_on && refines < PASS_LIMIT) begin
               refines++;
               orig = work;
               if (!smooth_pass(count)) break;
            end
         end
         for (int k = 0; k < count; k++) begin
            b.sx = work[0][k];
            b.sy = work[1][k];
            b.eop = (k + 1 == count);
            b.conv = ok;
            expected_points = {expected_points, b};
         end
         count = 0;
      endfunction

      function void check_beat(logic [63:0] data, logic last, logic conv);
         point_beat_type e;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h last %b conv %b",
                     $time, data, last, conv);
            errors++;
            return;
         end
         e = expected_points.pop_front();
         checked++;
         if (data[31:0] !== e.sx) begin
            $display("%0t: smooth_x expected %h actual %h", $time, e.sx, data[31:0]);
            errors++;
         end
         if (data[63:32] !== e.sy) begin
            $display("%0t: smooth_y expected %h actual %h", $time, e.sy, data[63:32]);
            errors++;
         end
         if (last !== e.eop) begin
            $display("%0t: end_of_path expected %b actual %b", $time, e.eop, last);
            errors++;
         end
         if (conv !== e.conv) begin
            $display("%0t: converged expected %b actual %b", $time, e.conv, conv);
            errors++;
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we = 0;
   logic [2:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   smoothing_scoreboard_type sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_on = 0;
   int hold_cycles = 0;
   int sent_points = 0;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   path_smoothing_sweep_unit dut (.*);

   // result side: check accepted beats, then decide readiness
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_beat(rsp_tdata, rsp_tlast, rsp_tuser);
      if (hold_on && hold_cycles < HOLD_LEN) begin
         hold_cycles <= hold_cycles + 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_point(coord_type x, coord_type y, bit last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {y, x};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_point(x, y, last);
      sent_points++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic configure(logic [15:0] dw, logic [15:0] sw, logic [31:0] tl,
                            logic [15:0] mi, logic re);
      logic [31:0] vals[5];
      logic [2:0]  idx[5];
      vals = '{dw, sw, tl, mi, re};
      idx = '{CSR_DATA_WEIGHT, CSR_SMOOTH_WEIGHT, CSR_TOLERANCE,
              CSR_MAX_ITERATIONS, CSR_REFINE_ENABLE};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1;
         csr_addr <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_reg(idx[i], vals[i]);
      end
      csr_we <= 0;
      @(posedge clock);
   endtask

   // mostly gentle paths around a random base, some full-range noise
   task automatic send_path(int n, bit noisy);
      coord_type bx, by;
      bx = $urandom;
      by = $urandom;
      for (int i = 0; i < n; i++) begin
         if (noisy) begin
            send_point($urandom, $urandom, i == n - 1);
         end else begin
            send_point(bx, by, i == n - 1);
            bx = bx + $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
            by = by + $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
         end
      end
   endtask

   task automatic random_config();
      logic [31:0] tl;
      case ($urandom_range(0, 3))
         0: tl = 0;
         1: tl = $urandom;
         default: tl = $urandom_range(0, 32'h2_0000);
      endcase
      configure($urandom_range(0, 65535), $urandom_range(0, 65535), tl,
                $urandom_range(0, 40), $urandom_range(0, 1));
   endtask

   initial begin
      int target;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults: single point, two points, gentle five point path
      send_point(32'sh7fff_ffff, 32'sh8000_0000, 1);
      send_point(32'sh8000_0000, 32'sh7fff_ffff, 0);
      send_point(32'sh0001_0000, 32'shffff_0000, 1);
      for (int i = 0; i < 5; i++)
         send_point(i * 32'sh1_0000, (i % 2) * 32'sh8000, i == 4);
      wait_drained();

      // full weights, saturating coordinates
      configure(16'hffff, 16'hffff, 32'hffff_ffff, 16'd3, 1'b1);
      send_point(32'sh7fff_ffff, 32'sh8000_0000, 0);
      send_point(32'sh8000_0000, 32'sh7fff_ffff, 0);
      send_point(32'sh7fff_ffff, 32'sh8000_0000, 1);
      wait_drained();

      // zero tolerance never converges
      configure(16'd6554, 16'd19661, 32'd0, 16'd5, 1'b0);
      for (int i = 0; i < 4; i++) send_point($urandom, $urandom, i == 3);
      wait_drained();

      // a single sweep always fails; then max sweeps with zero weights
      configure(16'd100, 16'd200, 32'd100, 16'd1, 1'b1);
      send_point(32'sd5, 32'sd7, 0);
      send_point(-32'sd5, -32'sd7, 1);
      wait_drained();
      configure(16'd0, 16'd0, 32'hffff_ffff, 16'hffff, 1'b1);
      for (int i = 0; i < 3; i++) send_point(i * 32'sh100, -i * 32'sh100, i == 2);
      wait_drained();

      // store overflow: the two extra points are dropped
      configure($urandom_range(0, 65535), $urandom_range(0, 65535), 32'd655, 16'd4, 1'b1);
      send_path(STORE_DEPTH + 2, 0);
      wait_drained();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 77 : 0;
         recv_idle_pct = (mode == 0) ? 77 : (mode == 1) ? 16 : 0;
         target = sent_points + 90;
         if (mode == 0) begin
            hold_on = 1;
            send_path(20, 0);
            send_path(6, 0);
            wait_drained();
         end
         random_config();
         while (sent_points < target) begin
            case ($urandom_range(0, 9))
               0: send_path(1, $urandom_range(0, 1));
               1: send_path($urandom_range(3, 8), 1);
               default: send_path($urandom_range(2, 10), 0);
            endcase
            if ($urandom_range(0, 3) == 0) begin
               wait_drained();
               random_config();
            end
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d paths of %0d points, %0d result beats checked",
               sb.paths, sent_points, sb.checked);
      $display("register extremes, overflow, saturation and stall phases included");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pss_pkg.sv
hw/rtl/pss_ram.sv
hw/rtl/pss_update.sv
hw/rtl/path_smoothing_sweep_unit.sv
test/path_smoothing_sweep_unit_tb.sv
